/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers. Empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* hw/rtl/tach_pkg.sv */
// ----------------------------------------------------------------------------
// tach_pkg
// Shared types and constants of the tachometer rpm meter.
// ----------------------------------------------------------------------------
`default_nettype none

package tach_pkg;

	localparam int DEB_BITS = 8;
	localparam int PPW_BITS = 4;
	localparam int NUM_BITS = 20;
	localparam int TMO_BITS = 16;
	localparam int RPM_BITS = 16;
	localparam int POS_IN_BITS = 16;
	localparam int TIME_IN_BITS = 32;
	localparam int DATA_BITS = 32;
	localparam int ADDR_BITS = 4;

	// register indexes (paddr[3:2])
	localparam logic [1:0] REG_DEBOUNCE = 2'd0;
	localparam logic [1:0] REG_PPW      = 2'd1;
	localparam logic [1:0] REG_NUMER    = 2'd2;
	localparam logic [1:0] REG_TIMEOUT  = 2'd3;

	// command codes of the input word
	localparam logic CMD_EDGE   = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	localparam logic [DEB_BITS-1:0] DEBOUNCE_RST = 8'd15;
	localparam logic [PPW_BITS-1:0] PPW_RST      = 4'd3;
	localparam logic [NUM_BITS-1:0] NUMER_RST    = 20'd60000;
	localparam logic [TMO_BITS-1:0] TIMEOUT_RST  = 16'd1000;

	typedef struct packed {
		logic [DEB_BITS-1:0] debounce_ms;
		logic [PPW_BITS-1:0] pulses_per_window;
		logic [NUM_BITS-1:0] rpm_numerator;
		logic [TMO_BITS-1:0] timeout_ms;
	} tach_cfg_t;

	typedef struct packed {
		logic busy;
		logic done;
	} tach_div_st_t;

endpackage

`default_nettype wire

/* hw/rtl/tach_regs.sv */
// ----------------------------------------------------------------------------
// tach_regs
// APB-style configuration registers, always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module tach_regs (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [tach_pkg::ADDR_BITS-1:0]  paddr,
	input  wire logic [tach_pkg::DATA_BITS-1:0]  pwdata,
	output logic      [tach_pkg::DATA_BITS-1:0]  prdata,
	output logic                                 pready,
	output tach_pkg::tach_cfg_t                  cfg
);

	tach_pkg::tach_cfg_t cfg_q;
	logic                wr_en;
	logic [1:0]          reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms       <= tach_pkg::DEBOUNCE_RST;
			cfg_q.pulses_per_window <= tach_pkg::PPW_RST;
			cfg_q.rpm_numerator     <= tach_pkg::NUMER_RST;
			cfg_q.timeout_ms        <= tach_pkg::TIMEOUT_RST;
		end else if (wr_en) begin
			case (reg_idx)
				tach_pkg::REG_DEBOUNCE: begin
					cfg_q.debounce_ms <= pwdata[tach_pkg::DEB_BITS-1:0];
				end
				tach_pkg::REG_PPW: begin
					cfg_q.pulses_per_window <= pwdata[tach_pkg::PPW_BITS-1:0];
				end
				tach_pkg::REG_NUMER: begin
					cfg_q.rpm_numerator <= pwdata[tach_pkg::NUM_BITS-1:0];
				end
				tach_pkg::REG_TIMEOUT: begin
					cfg_q.timeout_ms <= pwdata[tach_pkg::TMO_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			tach_pkg::REG_DEBOUNCE: prdata = tach_pkg::DATA_BITS'(cfg_q.debounce_ms);
			tach_pkg::REG_PPW:      prdata = tach_pkg::DATA_BITS'(cfg_q.pulses_per_window);
			tach_pkg::REG_NUMER:    prdata = tach_pkg::DATA_BITS'(cfg_q.rpm_numerator);
			tach_pkg::REG_TIMEOUT:  prdata = tach_pkg::DATA_BITS'(cfg_q.timeout_ms);
			default:                prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

/* hw/rtl/tach_div.sv */
// ----------------------------------------------------------------------------
// tach_div
// Restoring divider, one quotient bit per cycle, shared compare-subtract.
// ----------------------------------------------------------------------------
`default_nettype none

module tach_div #(
	parameter int TIME_BITS = 32
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic [tach_pkg::NUM_BITS-1:0]  numer,
	input  wire logic [TIME_BITS-1:0]           denom,
	output tach_pkg::tach_div_st_t              status,
	output logic      [tach_pkg::NUM_BITS-1:0]  quotient,
	output logic      [TIME_BITS-1:0]           remainder
);

	localparam int NB       = tach_pkg::NUM_BITS;
	localparam int CNT_BITS = $clog2(NB);

	logic [NB-1:0]        num_q;   // dividend bits shift out, quotient bits shift in
	logic [TIME_BITS-1:0] rem_q;
	logic [TIME_BITS-1:0] den_q;
	logic [CNT_BITS-1:0]  cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [TIME_BITS:0]   trial;
	logic [TIME_BITS:0]   diff;
	logic                 ge;

	assign trial = {rem_q, num_q[NB-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == CNT_BITS'(NB - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_BITS'(NB - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= numer;
			rem_q <= '0;
			den_q <= denom;
		end else if (busy_q) begin
			num_q <= {num_q[NB-2:0], ge};
			rem_q <= ge ? diff[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign quotient    = num_q;
	assign remainder   = rem_q;

endmodule

`default_nettype wire

/* hw/rtl/tachometer_rpm_meter.sv */
// ----------------------------------------------------------------------------
// tachometer_rpm_meter
// Period-based fan tachometer: debounced edge counting and rpm computation.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): one word per event. command 0 is a
// tachometer falling edge with its time_ms stamp; command 1 is a sample
// request carrying time_ms and encoder_position.
// Output channel (out_valid/out_stall): one rpm word per sample request,
// none per edge. The word sits in an output register until taken.
// Edges and most samples are handled in the accept cycle and the
// rpm word shows the next cycle. A sample that finds a closed window with a
// nonzero duration and an unchanged encoder position runs the 20-bit
// restoring divider, one quotient bit per cycle, with round half up on the
// quotient; the input is stalled until the divider is done.
// Edges are taken while an rpm word waits; a sample request is stalled
// while the output register is full and stalled.
// Reset (arst_n, async low) clears all timing state and held rpm and loads
// the register defaults: debounce 15 ms, 3 pulses, numerator 60000, timeout
// 1000 ms. The user makes config writes (APB port) only while idle; unenforced.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tachometer_rpm_meter #(
	parameter int TIME_BITS     = 32,
	parameter int POSITION_BITS = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// input channel
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic                                command,
	input  wire logic [tach_pkg::TIME_IN_BITS-1:0]   time_ms,
	input  wire logic signed [tach_pkg::POS_IN_BITS-1:0] encoder_position,
	// output channel
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic      [tach_pkg::RPM_BITS-1:0]       rpm,
	// configuration port
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [tach_pkg::ADDR_BITS-1:0]      paddr,
	input  wire logic [tach_pkg::DATA_BITS-1:0]      pwdata,
	output logic      [tach_pkg::DATA_BITS-1:0]      prdata,
	output logic                                     pready
);

	localparam int NB = tach_pkg::NUM_BITS;
	localparam int RB = tach_pkg::RPM_BITS;

	localparam logic [0:0] S_IDLE = 1'b0;
	localparam logic [0:0] S_DIV  = 1'b1;

	tach_pkg::tach_cfg_t    cfg;
	tach_pkg::tach_div_st_t div_st;

	logic [0:0]               state_q;
	logic [TIME_BITS-1:0]     last_edge_q;
	logic [3:0]               pulse_cnt_q;
	logic [TIME_BITS-1:0]     win_start_q;
	logic [TIME_BITS-1:0]     win_end_q;
	logic                     win_ready_q;
	logic [RB-1:0]            held_rpm_q;
	logic [TIME_BITS-1:0]     last_calc_q;
	logic [POSITION_BITS-1:0] last_pos_q;
	logic                     out_valid_q;
	logic [RB-1:0]            rpm_q;

	logic                     accept;
	logic [TIME_BITS-1:0]     now;
	logic [POSITION_BITS-1:0] pos;
	logic [TIME_BITS-1:0]     gap;
	logic [TIME_BITS-1:0]     span;
	logic [TIME_BITS-1:0]     since_calc;
	logic [3:0]               cnt_inc;
	logic                     moved;
	logic                     div_start;
	logic [NB-1:0]            quo;
	logic [TIME_BITS-1:0]     rem;
	logic                     round_up;
	logic [NB:0]              speed;
	logic [RB-1:0]            speed_sat;

	tach_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tach_div #(
		.TIME_BITS (TIME_BITS)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.numer     (cfg.rpm_numerator),
		.denom     (span),
		.status    (div_st),
		.quotient  (quo),
		.remainder (rem)
	);

	// samples wait for a free output register; everything waits on the divider
	assign in_stall = (state_q != S_IDLE) ||
	                  ((command == tach_pkg::CMD_SAMPLE) && out_valid_q && out_stall);
	assign accept   = in_valid && !in_stall;

	assign now        = TIME_BITS'(time_ms);
	assign pos        = POSITION_BITS'(encoder_position);  // sign-extends or truncates
	assign gap        = now - last_edge_q;
	assign span       = win_end_q - win_start_q;           // windows frozen while busy
	assign since_calc = now - last_calc_q;
	assign cnt_inc    = pulse_cnt_q + 4'd1;
	assign moved      = pos != last_pos_q;

	assign div_start = accept && (command == tach_pkg::CMD_SAMPLE) && !moved &&
	                   win_ready_q && (span != '0);

	// round half up: bump when twice the remainder reaches the divisor
	assign round_up  = {rem, 1'b0} >= {1'b0, span};
	assign speed     = {1'b0, quo} + (NB+1)'(round_up);
	assign speed_sat = (speed[NB:RB] != '0) ? {RB{1'b1}} : speed[RB-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			last_edge_q <= '0;
			pulse_cnt_q <= '0;
			win_start_q <= '0;
			win_end_q   <= '0;
			win_ready_q <= 1'b0;
			held_rpm_q  <= '0;
			last_calc_q <= '0;
			last_pos_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept && (command == tach_pkg::CMD_EDGE)) begin
						last_edge_q <= now;
						if (gap > TIME_BITS'(cfg.debounce_ms)) begin
							if (pulse_cnt_q == 4'd0) begin
								win_start_q <= now;
							end
							if (cnt_inc == cfg.pulses_per_window) begin
								win_end_q   <= now;
								win_ready_q <= 1'b1;
								pulse_cnt_q <= '0;
							end else begin
								pulse_cnt_q <= cnt_inc;
							end
						end
					end else if (accept) begin
						win_ready_q <= 1'b0;
						last_pos_q  <= pos;
						if (div_start) begin
							last_calc_q <= now;
							state_q     <= S_DIV;
						end else begin
							if (!moved && !win_ready_q &&
							    (since_calc > TIME_BITS'(cfg.timeout_ms))) begin
								held_rpm_q <= '0;
							end
						end
					end
				end
				S_DIV: begin
					if (div_st.done) begin
						state_q <= S_IDLE;
						if (speed_sat != '0) begin
							held_rpm_q <= speed_sat;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output word valid: set when a word is produced, cleared when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (((state_q == S_DIV) && div_st.done) ||
		             (accept && (command == tach_pkg::CMD_SAMPLE) && !div_start)) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output word: divider result (held rpm if zero), else zero on timeout or held rpm
	always_ff @(posedge clk) begin
		if (state_q == S_DIV) begin
			if (div_st.done) begin
				rpm_q <= (speed_sat != '0) ? speed_sat : held_rpm_q;
			end
		end else if (accept && (command == tach_pkg::CMD_SAMPLE) && !div_start) begin
			if (!moved && !win_ready_q && (since_calc > TIME_BITS'(cfg.timeout_ms))) begin
				rpm_q <= '0;
			end else begin
				rpm_q <= held_rpm_q;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign rpm       = rpm_q;

	// assertions
	`ASSERT_IMPLY(a_busy_stalls, clk, arst_n, state_q != S_IDLE, in_stall)
	`ASSERT_IMPLY(a_done_in_div, clk, arst_n, div_st.done, state_q == S_DIV)
	`ASSERT_IMPLY(a_sample_out_free, clk, arst_n, accept && (command == tach_pkg::CMD_SAMPLE),
		!(out_valid_q && out_stall))
	`ASSERT_NEXT(a_start_runs, clk, arst_n, div_start, div_st.busy && (state_q == S_DIV))

endmodule

`default_nettype wire
